>>> design/binary_morphology_window_top_macros.svh
// Assertion macros used by the checker of the morphology window block
`ifndef BINARY_MORPHOLOGY_WINDOW_TOP_MACROS_SVH
`define BINARY_MORPHOLOGY_WINDOW_TOP_MACROS_SVH

// Check outside reset only
`define BMW_CHECK(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bmw check failed");

// Check at every edge, reset included
`define BMW_CHECK_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bmw reset check failed");

`endif

>>> design/bmw_pkg.sv
// Shared constants for the binary morphology window block
`timescale 1ns / 1ps
package bmw_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_REACH_DEF = 8;
  localparam int HEIGHT_LIMIT  = 4096;

  localparam int PIX_W       = 8;
  localparam int OUT_DATA_W  = 8;
  localparam int MODE_W      = 1;
  localparam int FWIDTH_W    = 11;
  localparam int FHEIGHT_W   = 13;
  localparam int WSIZE_W     = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WSIZE  = 2'd3;

  localparam logic [MODE_W-1:0] MODE_DILATE = 1'b0;
  localparam logic [MODE_W-1:0] MODE_ERODE  = 1'b1;

  localparam logic [FWIDTH_W-1:0]  FWIDTH_RST  = 11'd640;
  localparam logic [FHEIGHT_W-1:0] FHEIGHT_RST = 13'd480;
  localparam logic [WSIZE_W-1:0]   WSIZE_RST   = 5'd3;

  localparam int OUT_FIFO_DEPTH = 3;

endpackage

>>> design/bmw_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module bmw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/binary_morphology_window_top.sv
// Binary dilation/erosion over a square window on a streamed raster
// Path: an accepted input is registered into the update stage, then written to the
//   output queue, where its result can be taken; output (X,Y) comes from the item at (X+half, Y+half).
// Throughput: one pixel per cycle while s_tready is high (it drops during the clearing
//   pass and when the output queue is full), set by the single read-modify-write pass over
//   the column history RAM (one read and one write port). Reset: registers return to
//   dilation, 640x480, window 3; a clearing pass then zeroes all MAX_WIDTH entries with s_tready low.
`timescale 1ns / 1ps
module binary_morphology_window_top #(
  parameter int MAX_WIDTH = bmw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_REACH = bmw_pkg::MAX_REACH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bmw_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel_value
  input  logic                            s_tuser,   // [0] start_of_frame
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bmw_pkg::OUT_DATA_W-1:0]  m_tdata,   // [0] result_pixel, [7:1] zero
  output logic                            m_tlast,   // end_of_frame
  input  logic                            cfg_we,
  input  logic [bmw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bmw_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int HW  = 2 * MAX_REACH;
  localparam int CW  = $clog2(MAX_WIDTH + MAX_REACH + 1);
  localparam int RW  = $clog2(HEIGHT_LIMIT + MAX_REACH + 1);
  localparam int HFW = $clog2(MAX_REACH + 1);
  localparam int FPW = $clog2(OUT_FIFO_DEPTH);
  localparam int FCW = $clog2(OUT_FIFO_DEPTH + 1);

  typedef struct packed {
    logic [AW-1:0] addr;
    logic          in_w;
    logic          row_zero;
    logic          col_zero;
    logic          hit;
    logic          emit;
    logic          last;
  } stage_t;

  // configuration registers
  logic [MODE_W-1:0]    morph_mode;
  logic [FWIDTH_W-1:0]  pix_per_row;
  logic [FHEIGHT_W-1:0] rows_per_frame;
  logic [WSIZE_W-1:0]   window_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      morph_mode     <= MODE_DILATE;
      pix_per_row    <= FWIDTH_RST;
      rows_per_frame <= FHEIGHT_RST;
      window_size    <= WSIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   morph_mode     <= cfg_data[MODE_W-1:0];
        CFG_WIDTH:  pix_per_row    <= cfg_data[FWIDTH_W-1:0];
        CFG_HEIGHT: rows_per_frame <= cfg_data[FHEIGHT_W-1:0];
        CFG_WSIZE:  window_size    <= cfg_data[WSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [CW-1:0]  w_lim, ext_w;
  logic [RW-1:0]  h_lim, ext_h;
  logic [HFW-1:0] half;
  logic [HW-1:0]  mask;
  logic [WSIZE_W-2:0] ws_half;

  always_comb begin
    ws_half = window_size[WSIZE_W-1:1];
    if (pix_per_row == '0) begin
      w_lim = CW'(1);
    end else if (32'(pix_per_row) > MAX_WIDTH) begin
      w_lim = CW'(MAX_WIDTH);
    end else begin
      w_lim = CW'(pix_per_row);
    end
    if (rows_per_frame == '0) begin
      h_lim = RW'(1);
    end else if (32'(rows_per_frame) > HEIGHT_LIMIT) begin
      h_lim = RW'(HEIGHT_LIMIT);
    end else begin
      h_lim = RW'(rows_per_frame);
    end
    if (32'(ws_half) > MAX_REACH) begin
      half = HFW'(MAX_REACH);
    end else begin
      half = HFW'(ws_half);
    end
    ext_w = w_lim + CW'(half);
    ext_h = h_lim + RW'(half);
    for (int i = 0; i < HW; i++) begin
      mask[i] = (i < 2 * int'(half));
    end
  end

  // clearing pass after reset
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(MAX_WIDTH - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // output queue
  logic [1:0]     out_q [OUT_FIFO_DEPTH];
  logic [FPW-1:0] wr_ptr, rd_ptr;
  logic [FCW-1:0] out_count;
  logic           push, pop;
  logic           s1_valid;
  stage_t         s1;

  assign m_tvalid = (out_count != '0);
  assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_q[rd_ptr][0]};
  assign m_tlast  = out_q[rd_ptr][1];
  assign pop      = m_tvalid && m_tready;
  assign s_tready = !rst && !clr_busy &&
                    (({1'b0, out_count} + {{FCW{1'b0}}, s1_valid}) < (FCW+1)'(OUT_FIFO_DEPTH));

  // accept stage: position and read issue
  logic          acc;
  logic [CW-1:0] col, c0, col_next;
  logic [RW-1:0] row, r0, row_next;
  logic          in_w0, in_h0, set0, hit0, emit0, last0, wrap0;
  stage_t        s0;

  always_comb begin
    acc   = s_tvalid && s_tready;
    c0    = s_tuser ? '0 : col;
    r0    = s_tuser ? '0 : row;
    in_w0 = c0 < w_lim;
    in_h0 = r0 < h_lim;
    set0  = s_tdata != '0;
    hit0  = in_w0 && in_h0 && ((morph_mode == MODE_DILATE) ? set0 : !set0);
    emit0 = (c0 >= CW'(half)) && (r0 >= RW'(half));
    last0 = (c0 == ext_w - CW'(1)) && (r0 == ext_h - RW'(1));
    wrap0 = ({1'b0, c0} + (CW+1)'(1)) >= {1'b0, ext_w};
    if (wrap0) begin
      col_next = '0;
      row_next = (({1'b0, r0} + (RW+1)'(1)) >= {1'b0, ext_h}) ? '0 : r0 + RW'(1);
    end else begin
      col_next = c0 + CW'(1);
      row_next = r0;
    end
    s0.addr     = c0[AW-1:0];
    s0.in_w     = in_w0;
    s0.row_zero = (r0 == '0);
    s0.col_zero = (c0 == '0);
    s0.hit      = hit0;
    s0.emit     = emit0;
    s0.last     = last0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
      if (acc) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1 <= s0;
    end
  end

  // update stage: modify the column history and slide the row window
  logic [HW-1:0] rd_data, hist_old, hist_new, rw_old, rw_new, row_window;
  logic          col_hit, win_hit, res;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [HW-1:0] mem_data;
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [HW-1:0] fwd_data;

  always_comb begin
    if (s1.row_zero) begin
      hist_old = '0;
    end else if (fwd_valid && (fwd_addr == s1.addr)) begin
      hist_old = fwd_data;  // write in the read cycle, RAM returned stale data
    end else begin
      hist_old = rd_data;
    end
    hist_new = {hist_old[HW-2:0], s1.hit} & mask;
    col_hit  = s1.in_w && (hist_new != '0);
    rw_old   = s1.col_zero ? '0 : row_window;
    rw_new   = {rw_old[HW-2:0], col_hit} & mask;
    win_hit  = rw_new != '0;
    res      = (morph_mode == MODE_ERODE) ? !win_hit : win_hit;
    push     = s1_valid && s1.emit;
    if (clr_busy) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr;
      mem_data = '0;
    end else begin
      mem_we   = s1_valid && s1.in_w;
      mem_addr = s1.addr;
      mem_data = hist_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_window <= '0;
      fwd_valid  <= 1'b0;
    end else begin
      fwd_valid <= mem_we;
      if (s1_valid) begin
        row_window <= rw_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= mem_addr;
    fwd_data <= mem_data;
  end

  bmw_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_WIDTH)
  ) u_hist_ram (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_addr),
    .wr_data (mem_data),
    .rd_addr (s0.addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FPW'(OUT_FIFO_DEPTH - 1)) ? '0 : wr_ptr + FPW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FPW'(OUT_FIFO_DEPTH - 1)) ? '0 : rd_ptr + FPW'(1);
      end
      if (push && !pop) begin
        out_count <= out_count + FCW'(1);
      end else if (pop && !push) begin
        out_count <= out_count - FCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_q[wr_ptr] <= {s1.last, res};
    end
  end

endmodule

>>> design/bmw_checker.sv
// Port-level checks for the morphology window block, bound to the top level
`timescale 1ns / 1ps
`include "binary_morphology_window_top_macros.svh"
module bmw_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bmw_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);

  // hold input off while the history RAM is cleared
  `BMW_CHECK_RST(a_no_ready_after_rst, rst |=> !s_tready)
  `BMW_CHECK_RST(a_no_result_after_rst, rst |=> !m_tvalid)
  // a new result needs an accepted transaction, registered through the update stage and the output queue
  `BMW_CHECK(a_result_has_source, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
  `BMW_CHECK(a_result_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind binary_morphology_window_top bmw_checker u_bmw_checker (.*);

>>> bench/binary_morphology_window_top_tb.sv
// Self-checking bench for the binary morphology window: raster streams against a window predictor
`timescale 1ns / 1ps
module binary_morphology_window_top_tb;
  import bmw_pkg::*;

  localparam int RANDOM_ITEMS   = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic result_pixel;
    logic end_of_frame;
  } morph_result_t;

  // Window predictor plus the queue of results it still owes
  class morph_scoreboard;
    logic [MODE_W-1:0]          mode;
    logic [FWIDTH_W-1:0]        fwidth;
    logic [FHEIGHT_W-1:0]       fheight;
    logic [WSIZE_W-1:0]         wsize;
    logic [2*MAX_REACH_DEF-1:0] col_hist [MAX_WIDTH_DEF];
    logic [2*MAX_REACH_DEF-1:0] row_hits;
    int unsigned                col;
    int unsigned                row;
    morph_result_t              pending [$];
    int unsigned                pixels_in;
    int unsigned                results_out;
    int unsigned                frame_ends;
    int unsigned                errors;

    function new();
      mode    = MODE_DILATE;
      fwidth  = FWIDTH_RST;
      fheight = FHEIGHT_RST;
      wsize   = WSIZE_RST;
      foreach (col_hist[i]) col_hist[i] = '0;
      row_hits    = '0;
      col         = 0;
      row         = 0;
      pixels_in   = 0;
      results_out = 0;
      frame_ends  = 0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MODE:   mode = val[MODE_W-1:0];
        CFG_WIDTH:  fwidth = val[FWIDTH_W-1:0];
        CFG_HEIGHT: fheight = val[FHEIGHT_W-1:0];
        CFG_WSIZE:  wsize = val[WSIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = (fwidth == 0) ? 1 : fwidth;
      return (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
    endfunction

    function int unsigned eff_height();
      int unsigned h;
      h = (fheight == 0) ? 1 : fheight;
      return (h > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h;
    endfunction

    function int unsigned reach();
      int unsigned half;
      half = wsize >> 1;
      return (half > MAX_REACH_DEF) ? MAX_REACH_DEF : half;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix, logic sof);
      int unsigned   w, h, half, ext_w, ext_h;
      logic [31:0]   mask, hist, rw;
      logic          hit, col_hit;
      morph_result_t res;
      w     = eff_width();
      h     = eff_height();
      half  = reach();
      ext_w = w + half;
      ext_h = h + half;
      mask  = (32'd1 << (2 * half)) - 1;
      pixels_in++;
      if (sof) begin
        col = 0;
        row = 0;
      end
      // a hit is a set source when dilating, a clear one when eroding
      hit = (col < w && row < h) && ((mode == MODE_DILATE) ? (pix != 0) : (pix == 0));
      col_hit = 1'b0;
      if (col < w) begin
        hist = (row == 0) ? 32'd0 : 32'(col_hist[col]);
        hist = ((hist << 1) | 32'(hit)) & mask;
        col_hist[col] = hist[2*MAX_REACH_DEF-1:0];
        col_hit = (hist != 0);
      end
      rw = (col == 0) ? 32'd0 : 32'(row_hits);
      rw = ((rw << 1) | 32'(col_hit)) & mask;
      row_hits = rw[2*MAX_REACH_DEF-1:0];
      if (col >= half && row >= half) begin
        res.result_pixel = (mode == MODE_DILATE) ? (rw != 0) : (rw == 0);
        res.end_of_frame = (col == ext_w - 1 && row == ext_h - 1);
        pending.push_back(res);
      end
      // past the last column wrap the row; past the last row wrap the frame
      if (col + 1 >= ext_w) begin
        col = 0;
        row = (row + 1 >= ext_h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
      morph_result_t want;
      results_out++;
      if (last) frame_ends++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result %0d with nothing pending: data 0x%02h last %0d",
                   results_out, data, last);
        return;
      end
      want = pending.pop_front();
      if (data !== {{(OUT_DATA_W-1){1'b0}}, want.result_pixel} ||
          last !== want.end_of_frame) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result %0d mismatch: expected pixel %0d last %0d, got data 0x%02h last %0d",
                   results_out, want.result_pixel, want.end_of_frame, data, last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata = '0;      // [7:0] pixel_value
  logic                  s_tuser = 1'b0;    // [0] start_of_frame
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;           // [0] result_pixel, [7:1] zero
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  morph_scoreboard sb;
  int unsigned     settings_used = 0;
  int unsigned     idle_cycles = 0;
  int              hold_req = 0;
  int              hold_done = 0;
  int              hold_left = 0;
  int              stall_left = 0;
  int              calm_left = 0;
  bit              busy;

  binary_morphology_window_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] make_pixel(int density);
    if ($urandom_range(0, 99) < density) return PIX_W'($urandom_range(1, 255));
    return '0;
  endfunction

  // Receiver: random stalls, calm stretches, and on request one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = HOLD_CYCLES - 1;
      m_tready = 1'b0;
    end else if (calm_left > 0) begin
      m_tready = 1'b1;
      calm_left--;
    end else if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      m_tready = 1'b1;
      if ($urandom_range(0, 199) == 0) calm_left = 150;
      else stall_left = gap_len();
    end
  end

  // Check results before noting inputs; the watchdog counts cycles with no transaction
  always @(posedge clk) begin
    if (!rst) begin
      busy = 1'b0;
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata, m_tlast);
        busy = 1'b1;
      end
      if (s_tvalid && s_tready) begin
        sb.note_pixel(s_tdata, s_tuser);
        busy = 1'b1;
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no transaction for %0d cycles, %0d results still pending",
                 WATCHDOG_LIMIT, sb.pending.size());
        $display("binary_morphology_window_top test failed");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the transaction and its gap
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof, input bit calm);
    int gap;
    s_tvalid = 1'b1;
    s_tdata  = pix;
    s_tuser  = sof;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every owed result has come out, plus pipeline slack
  task automatic settle();
    s_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(val);
    sb.set_reg(idx, CFG_DATA_W'(val));
    @(negedge clk);
  endtask

  task automatic configure(input logic [MODE_W-1:0] m, input int unsigned w,
                           input int unsigned h, input int unsigned ws);
    settle();
    put_reg(CFG_MODE, 32'(m));
    put_reg(CFG_WIDTH, w);
    put_reg(CFG_HEIGHT, h);
    put_reg(CFG_WSIZE, ws);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // Mostly whole frames; some cut short, some restarted midway, some without a start mark
  task automatic send_frame(input int density, input bit calm);
    int unsigned total, count, restart_at;
    int          kind;
    logic        sof;
    total = (sb.eff_width() + sb.reach()) * (sb.eff_height() + sb.reach());
    kind = $urandom_range(0, 9);
    count = total;
    restart_at = 0;
    if (kind == 7) count = $urandom_range(1, total);
    if (kind == 8) begin
      restart_at = $urandom_range(1, total);
      count = total + restart_at;
    end
    for (int unsigned i = 0; i < count; i++) begin
      sof = (i == 0 && kind != 9) || (restart_at != 0 && i == restart_at);
      send_pixel(make_pixel(density), sof, calm);
    end
  endtask

  initial begin
    logic [PIX_W-1:0] pattern [12];
    int unsigned      base, w, h, ws, frames, density;
    logic [MODE_W-1:0] m;
    bit               calm;

    sb = new();
    pattern = '{8'h00, 8'hFF, 8'h00, 8'hAA, 8'h01, 8'h00, 8'h80, 8'h55,
                8'h00, 8'h7F, 8'hFE, 8'h00};
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // a few pixels at the reset settings, held off by the clearing pass
    send_pixel(8'hFF, 1'b1, 1'b0);
    send_pixel(8'h00, 1'b0, 1'b0);
    send_pixel(8'h01, 1'b0, 1'b0);

    // one small frame, dilated then eroded
    configure(MODE_DILATE, 3, 2, 3);
    for (int i = 0; i < 12; i++) send_pixel(pattern[i], i == 0, 1'b0);
    configure(MODE_ERODE, 3, 2, 3);
    for (int i = 0; i < 12; i++) send_pixel(pattern[i], i == 0, 1'b0);

    // widest windows: largest legal size and the saturating one
    configure(MODE_ERODE, 3, 2, 17);
    send_frame(90, 1'b0);
    configure(MODE_DILATE, 5, 4, 31);
    send_frame(10, 1'b0);

    // random small frames
    base = sb.pixels_in;
    while (sb.pixels_in < base + RANDOM_ITEMS) begin
      m = MODE_W'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0:       w = 0;
        1:       w = 1;
        default: w = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 19))
        0:       h = 0;
        1:       h = 1;
        default: h = $urandom_range(1, 10);
      endcase
      case ($urandom_range(0, 9))
        0:       ws = 31;
        1, 2:    ws = $urandom_range(8, 17);
        default: ws = $urandom_range(0, 7);
      endcase
      configure(m, w, h, ws);
      calm = ($urandom_range(0, 3) == 0);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        case ($urandom_range(0, 5))
          0:       density = 0;
          1:       density = 5;
          2:       density = 30;
          3:       density = 60;
          4:       density = 95;
          default: density = 100;
        endcase
        send_frame(density, calm);
      end
    end

    // full width: receiver holds off while the sender keeps offering
    configure(MODE_DILATE, 1024, 2, 3);
    hold_req++;
    for (int i = 0; i < 1065; i++) send_pixel(make_pixel(5), i == 0, 1'b1);

    // oversize width saturates
    configure(MODE_ERODE, 2047, 3, 0);
    for (int i = 0; i < 40; i++) send_pixel(make_pixel(97), i == 0, 1'b0);

    // tallest frame, first rows only
    configure(MODE_ERODE, 1, 4096, 1);
    for (int i = 0; i < 30; i++) send_pixel(make_pixel(90), i == 0, 1'b0);

    // oversize height saturates
    configure(MODE_DILATE, 1, 8191, 2);
    for (int i = 0; i < 30; i++) send_pixel(make_pixel(50), i == 0, 1'b0);

    settle();
    repeat (16) @(posedge clk);

    $display("covered %0d pixels and %0d results over %0d register settings, %0d frame ends",
             sb.pixels_in, sb.results_out, settings_used, sb.frame_ends);
    $display("both modes; widths 0..1024 and oversize, heights 0..4096 and oversize, sizes 0..31");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("binary_morphology_window_top test passed");
    end else begin
      $display("%0d mismatches, %0d results never came", sb.errors, sb.pending.size());
      $display("binary_morphology_window_top test failed");
    end
    $finish;
  end

endmodule
